// ===== rtl/bns_pkg.sv =====
// Shared constants, widths and status codes for the buzzer note sequencer.
// Used by bns_div and buzzer_note_sequencer_core; depends on nothing.
package bns_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int PITCH_W = 16;
  localparam int DIVR_W  = 8;
  localparam int WHOLE_W = 16;
  localparam int DUR_W   = 17;
  localparam int NOTE_W  = PITCH_W + DUR_W;

  // bit-serial divider: one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(WHOLE_W + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_NOTE   = 1'd1;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_ZERO_DIV = 2'd2,
    STAT_DISABLED = 2'd3
  } status_t;

endpackage

// ===== rtl/bns_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module bns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bns_div.sv =====
// Bit-serial restoring divider: whole-note time over the divider magnitude.
// Depends on bns_pkg; one quotient bit per cycle, and a start while busy restarts the division.
module bns_div
  import bns_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WHOLE_W-1:0] dividend,
  input  logic [DIVR_W-1:0]  divisor,
  output logic               done,
  output logic [WHOLE_W-1:0] quotient
);

  logic [DIVR_W-1:0]    rem;
  logic [DIVR_W-1:0]    dsr;
  logic [WHOLE_W-1:0]   dvd;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVR_W:0]      trial;
  logic                 qbit;
  logic [DIVR_W:0]      diff;

  assign trial    = {rem, dvd[WHOLE_W-1]};
  assign qbit     = (trial >= {1'b0, dsr});
  assign diff     = trial - {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (start) begin
        cnt  <= DIV_CNT_W'(WHOLE_W);
        done <= 1'b0;
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == DIV_CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  // shift the dividend out at the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
    end else if (cnt != '0) begin
      rem <= qbit ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      dvd <= {dvd[WHOLE_W-2:0], qbit};
    end
  end

endmodule

// ===== rtl/buzzer_note_sequencer_core.sv =====
// Channel  | handshake          | payload
// s_       | s_tvalid/s_tready  | s_tuser action, s_tdata note_pitch, note_divider
// m_       | m_tvalid/m_tready  | m_tdata tone_on, tone_pitch, status
// cfg_     | cfg_wr_en          | cfg_index, cfg_data
// An append passes through accept, the bit-serial divider, store and result.
// A tick goes from accept to result, with a RAM read between when it pops a note.
// A disabled or dropped request goes from accept to result. The next request is taken
// while a result waits in the output register; a new result waits for that register.
// rst is synchronous; the note RAM needs no clearing after reset.
// Top level of the buzzer note sequencer; depends on bns_pkg, bns_ram, bns_div.
module buzzer_note_sequencer_core
  import bns_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,     // [15:0] note_pitch, [23:16] note_divider
  input  logic                 s_tuser,     // [0] action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,     // [0] tone_on, [16:1] tone_pitch, [18:17] status
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WHOLE_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_OUT
  } state_t;

  state_t state;

  logic               sound_enable;
  logic [WHOLE_W-1:0] whole_note_ms;

  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   note_count;
  logic [DUR_W-1:0]   time_left;
  logic [PITCH_W-1:0] current_pitch;
  logic               sounding;
  logic [PITCH_W-1:0] pitch_q;
  logic               dotted_q;
  status_t            stat_q;

  logic                     accept;
  logic                     in_action;
  logic [PITCH_W-1:0]       in_pitch;
  logic signed [DIVR_W-1:0] in_divider;
  logic [DIVR_W-1:0]        mag;
  logic [DUR_W-1:0]         tl_dec;
  logic                     q_full;
  logic                     start_div;
  logic                     pop;
  logic                     out_load;

  logic               div_done;
  logic [WHOLE_W-1:0] quotient;
  logic [DUR_W-1:0]   dur;
  logic [NOTE_W-1:0]  ram_rdata;
  logic               ram_we;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign in_action  = s_tuser;
  assign in_pitch   = s_tdata[15:0];
  assign in_divider = s_tdata[23:16];

  // two's complement magnitude; -128 comes out as 128
  assign mag    = in_divider[DIVR_W-1] ? (DIVR_W'(0) - in_divider) : in_divider;
  assign tl_dec = (time_left != '0) ? time_left - 1'b1 : '0;
  assign q_full = (note_count == CNT_W'(QUEUE_DEPTH));

  assign start_div = accept && sound_enable && (in_action == ACT_APPEND) &&
                     (mag != '0) && !q_full;
  assign pop       = accept && sound_enable && (in_action == ACT_TICK) &&
                     (tl_dec == '0) && (note_count != '0);
  assign out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);

  // dotted note adds half, truncated
  assign dur    = dotted_q ? ({1'b0, quotient} + DUR_W'(quotient >> 1))
                           : {1'b0, quotient};
  assign ram_we = (state == ST_DIV) && div_done;

  bns_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_div),
    .dividend (whole_note_ms),
    .divisor  (mag),
    .done     (div_done),
    .quotient (quotient)
  );

  bns_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata ({pitch_q, dur}),
    .re    (pop),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enable  <= 1'b1;
      whole_note_ms <= WHOLE_W'(2000);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SOUND_ENABLE: sound_enable  <= cfg_data[0];
        CFG_WHOLE_NOTE:   whole_note_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      note_count    <= '0;
      time_left     <= '0;
      current_pitch <= '0;
      sounding      <= 1'b0;
      stat_q        <= STAT_OK;
      m_tvalid      <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pitch_q  <= in_pitch;
            dotted_q <= in_divider[DIVR_W-1];
            priority if (!sound_enable) begin
              stat_q <= STAT_DISABLED;
              state  <= ST_OUT;
            end else if (in_action == ACT_APPEND) begin
              priority if (mag == '0) begin
                stat_q <= STAT_ZERO_DIV;
                state  <= ST_OUT;
              end else if (q_full) begin
                stat_q <= STAT_FULL;
                state  <= ST_OUT;
              end else begin
                stat_q <= STAT_OK;
                state  <= ST_DIV;
              end
            end else begin
              stat_q    <= STAT_OK;
              time_left <= tl_dec;
              if ((tl_dec == '0) && (note_count != '0)) begin
                state <= ST_RD;
              end else begin
                state <= ST_OUT;
                if (tl_dec == '0) begin
                  current_pitch <= '0;
                  sounding      <= 1'b0;
                end
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            wr_ptr     <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
            note_count <= note_count + 1'b1;
            state      <= ST_OUT;
          end
        end
        ST_RD: begin
          current_pitch <= ram_rdata[NOTE_W-1:DUR_W];
          time_left     <= ram_rdata[DUR_W-1:0];
          sounding      <= 1'b1;
          rd_ptr        <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
          note_count    <= note_count - 1'b1;
          state         <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            m_tdata  <= {5'd0, stat_q, (sounding ? current_pitch : PITCH_W'(0)), sounding};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    note_count <= CNT_W'(QUEUE_DEPTH))
    else $error("note count above queue depth");

  a_silent_pitch: assert property (@(posedge clk) disable iff (rst)
    !sounding |-> (current_pitch == '0))
    else $error("silent output holds a pitch");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> (note_count != '0))
    else $error("pop from empty queue");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside append");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (note_count == $past(note_count) + 1'b1))
    else $error("stored note not counted");
`endif

endmodule
